// ===== rtl/reas_pkg.sv =====
`default_nettype none
package reas_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int NPIX       = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(NPIX);
    localparam int DIM_W      = 9;
    localparam int CNT_W      = ADDR_W + 1;
    localparam int SIG_CH     = 3;
    localparam int GUIDE_CH   = 3;
    localparam int LANES      = SIG_CH + 1;
    localparam int ACC_W      = 56;
    localparam int DEC_W      = 17;
    localparam int RS_W       = 48;
    localparam int RW_W       = 40;
    localparam int CW_W       = 48;

    localparam logic [ACC_W-1:0] RS_MAX  = ACC_W'((64'd1 << RS_W) - 64'd1);
    localparam logic [ACC_W-1:0] RW_MAX  = ACC_W'((64'd1 << RW_W) - 64'd1);
    localparam logic [ACC_W-1:0] CS_MAX  = ACC_W'((64'd1 << ACC_W) - 64'd1);
    localparam logic [ACC_W-1:0] CW_MAX  = ACC_W'((64'd1 << CW_W) - 64'd1);
    localparam logic [ACC_W-1:0] ONE_ACC = ACC_W'(64'd1 << 16);
    localparam logic [DEC_W-1:0] ONE_DEC = DEC_W'(32'd1 << 16);

    // configuration register indexes
    localparam logic [1:0] CFG_THRESH = 2'd0;
    localparam logic [1:0] CFG_DECAY  = 2'd1;
    localparam logic [1:0] CFG_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_HEIGHT = 2'd3;

    // input item function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef struct packed {
        logic [SIG_CH-1:0][15:0]    sig;
        logic [GUIDE_CH-1:0][7:0]   guide;
        logic [SIG_CH-1:0][RS_W-1:0] row_s;
        logic [RW_W-1:0]            row_w;
        logic [SIG_CH-1:0][ACC_W-1:0] col_s;
        logic [CW_W-1:0]            col_w;
    } t_word;

    typedef struct packed {
        logic scale_en;
        logic step;
        logic use_prev;
        logic bwd;
    } t_lane_ctl;

endpackage
`default_nettype wire

// ===== rtl/reas_ram.sv =====
`default_nettype none
module reas_ram #(
    parameter int DW    = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/reas_lane.sv =====
`default_nettype none
module reas_lane import reas_pkg::*; (
    input  logic             i_clk,
    input  t_lane_ctl        i_ctl,
    input  logic [DEC_W-1:0] i_decay,
    input  logic [ACC_W-1:0] i_x,
    input  logic [ACC_W-1:0] i_fwd,
    input  logic [ACC_W-1:0] i_maxv,
    output logic [ACC_W-1:0] o_out
);

    localparam int HI_W = ACC_W - 16 + DEC_W;
    localparam int LO_W = 16 + DEC_W;

    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] r_scaled;
    logic [HI_W-1:0]  hi;
    logic [LO_W-1:0]  lo;
    logic [ACC_W+1:0] sc_sum;
    logic [ACC_W-1:0] prev;
    logic [ACC_W:0]   s1;
    logic [ACC_W:0]   s2;
    logic [ACC_W-1:0] acc_new;
    logic [ACC_W-1:0] sub;
    logic [ACC_W-1:0] out_b;

    // (acc * decay) >> 16, split so the fraction part rounds down exactly
    always_comb begin
        hi     = r_acc[ACC_W-1:16] * i_decay;
        lo     = r_acc[15:0] * i_decay;
        sc_sum = (ACC_W+2)'(hi) + (ACC_W+2)'(lo[LO_W-1:16]);
    end

    always_comb begin
        prev    = i_ctl.use_prev ? r_scaled : '0;
        s1      = {1'b0, i_x} + {1'b0, prev};
        acc_new = (s1 > {1'b0, i_maxv}) ? i_maxv : s1[ACC_W-1:0];
        // backward: forward result minus centre, plus backward accumulator
        sub     = (i_fwd > i_x) ? (i_fwd - i_x) : '0;
        s2      = {1'b0, sub} + {1'b0, acc_new};
        out_b   = (s2 > {1'b0, i_maxv}) ? i_maxv : s2[ACC_W-1:0];
        o_out   = i_ctl.bwd ? out_b : acc_new;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.scale_en) begin
            r_scaled <= sc_sum[ACC_W-1:0];
        end
        if (i_ctl.step) begin
            r_acc <= acc_new;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/recursive_edge_aware_smoothing_top.sv =====
// Edge-aware recursive smoothing of one frame held in a single pixel memory.
// A load (func 0) stores one pixel in column-major order; the load that
// completes the frame starts filtering, which visits every pixel four times
// (row forward, row backward, column forward, column backward), each visit a
// read of the pixel word while the decayed accumulator is scaled, then an
// update that writes it back. Input is held off until filtering is done.
// A read (func 1) passes through one memory read, then 16 steps of a
// restoring divide run in parallel for the three channels on a shared
// divisor, then the output register. A read before the frame is filtered
// skips the read and the divider and answers with status 1. The output
// register lets the next item in while a result waits to be taken.
`default_nettype none
module recursive_edge_aware_smoothing_top import reas_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [16:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_func,
    input  logic [15:0] i_sig_c0,
    input  logic [15:0] i_sig_c1,
    input  logic [15:0] i_sig_c2,
    input  logic [7:0]  i_guide_c0,
    input  logic [7:0]  i_guide_c1,
    input  logic [7:0]  i_guide_c2,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_out_c0,
    output logic [15:0] o_out_c1,
    output logic [15:0] o_out_c2,
    output logic        o_status,
    output logic        o_frame_end
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FRD   = 3'd1;
    localparam logic [2:0] ST_FWR   = 3'd2;
    localparam logic [2:0] ST_RWAIT = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_PUSH  = 3'd5;

    localparam int DVS_W = ACC_W + 7;

    logic [2:0]        r_state;
    logic [7:0]        r_thr;
    logic [DEC_W-1:0]  r_decay;
    logic [DIM_W-1:0]  r_fw;
    logic [DIM_W-1:0]  r_fh;
    logic [CNT_W-1:0]  r_load_cnt;
    logic [CNT_W-1:0]  r_read_cnt;
    logic              r_ready;
    logic [DIM_W-1:0]  r_w;
    logic [DIM_W-1:0]  r_h;
    logic [CNT_W-1:0]  r_size;
    logic              r_col;
    logic              r_bwd;
    logic [DIM_W-1:0]  r_line;
    logic [DIM_W-1:0]  r_idx;
    logic [ADDR_W-1:0] r_addr;
    logic [GUIDE_CH-1:0][7:0] r_prev_guide;

    logic [SIG_CH-1:0][ACC_W-1:0] r_rem;
    logic [SIG_CH-1:0][15:0]      r_q;
    logic [SIG_CH-1:0]            r_dsat;
    logic [DVS_W-1:0]             r_dvs;
    logic                         r_dzero;
    logic [3:0]                   r_div_cnt;
    logic                         r_res_status;
    logic                         r_res_end;

    logic                    r_out_valid;
    logic [SIG_CH-1:0][15:0] r_out_c;
    logic                    r_out_status;
    logic                    r_out_end;

    // frame geometry and load bookkeeping
    logic [DIM_W-1:0]   cw;
    logic [DIM_W-1:0]   ch;
    logic [2*DIM_W-1:0] size_prod;
    logic [CNT_W-1:0]   cur_size;
    logic               load_store;
    logic [CNT_W-1:0]   load_next;
    logic               in_fire;
    logic               is_load;
    logic               is_read;
    logic [CNT_W-1:0]   read_next;
    logic               push_fire;
    logic [DEC_W-1:0]   decay_q;

    // filter sequencing
    logic [DIM_W-1:0]  n_len;
    logic [DIM_W-1:0]  n_lines;
    logic [DIM_W-1:0]  last_idx;
    logic              first_el;
    logic [9:0]        gdiff;
    logic [9:0]        thr3;
    logic              link;
    logic [ADDR_W-1:0] el_step;
    logic [ADDR_W-1:0] line_step;

    t_lane_ctl                    lane_ctl;
    logic [LANES-1:0][ACC_W-1:0]  lane_x;
    logic [LANES-1:0][ACC_W-1:0]  lane_fwd;
    logic [LANES-1:0][ACC_W-1:0]  lane_max;
    logic [LANES-1:0][ACC_W-1:0]  lane_out;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    t_word             mem_wdata;
    t_word             mem_rd;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign is_load    = in_fire && (i_func == FUNC_LOAD);
    assign is_read    = in_fire && (i_func == FUNC_READ);
    assign push_fire  = (r_state == ST_PUSH) && (!r_out_valid || i_out_ready);

    always_comb begin
        cw = (r_fw == '0) ? DIM_W'(1) :
             (r_fw > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : r_fw;
        ch = (r_fh == '0) ? DIM_W'(1) :
             (r_fh > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : r_fh;
        size_prod  = {{DIM_W{1'b0}}, cw} * {{DIM_W{1'b0}}, ch};
        cur_size   = size_prod[CNT_W-1:0];
        load_store = (r_load_cnt < cur_size);
        load_next  = r_load_cnt + (load_store ? CNT_W'(1) : CNT_W'(0));
        read_next  = r_read_cnt + CNT_W'(1);
        decay_q    = (r_decay > ONE_DEC) ? ONE_DEC : r_decay;
    end

    always_comb begin
        n_len     = r_col ? r_h : r_w;
        n_lines   = r_col ? r_w : r_h;
        last_idx  = n_len - DIM_W'(1);
        first_el  = r_bwd ? (r_idx == last_idx) : (r_idx == '0);
        el_step   = r_col ? ADDR_W'(1) : ADDR_W'(r_h);
        line_step = r_col ? ADDR_W'(r_h) : ADDR_W'(1);
        thr3      = {2'b00, r_thr} + {1'b0, r_thr, 1'b0};
        gdiff     = '0;
        for (int c = 0; c < GUIDE_CH; c++) begin
            if (mem_rd.guide[c] > r_prev_guide[c]) begin
                gdiff = gdiff + 10'(mem_rd.guide[c] - r_prev_guide[c]);
            end else begin
                gdiff = gdiff + 10'(r_prev_guide[c] - mem_rd.guide[c]);
            end
        end
        link = (gdiff <= thr3);
    end

    always_comb begin
        lane_ctl.scale_en = (r_state == ST_FRD);
        lane_ctl.step     = (r_state == ST_FWR);
        lane_ctl.use_prev = !first_el && link;
        lane_ctl.bwd      = r_bwd;
        for (int l = 0; l < SIG_CH; l++) begin
            lane_x[l]   = r_col ? ACC_W'(mem_rd.row_s[l]) : ACC_W'({mem_rd.sig[l], 16'h0000});
            lane_fwd[l] = r_col ? mem_rd.col_s[l] : ACC_W'(mem_rd.row_s[l]);
            lane_max[l] = r_col ? CS_MAX : RS_MAX;
        end
        lane_x[SIG_CH]   = r_col ? ACC_W'(mem_rd.row_w) : ONE_ACC;
        lane_fwd[SIG_CH] = r_col ? ACC_W'(mem_rd.col_w) : ACC_W'(mem_rd.row_w);
        lane_max[SIG_CH] = r_col ? CW_MAX : RW_MAX;
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        reas_lane u_lane (
            .i_clk   (i_clk),
            .i_ctl   (lane_ctl),
            .i_decay (decay_q),
            .i_x     (lane_x[g]),
            .i_fwd   (lane_fwd[g]),
            .i_maxv  (lane_max[g]),
            .o_out   (lane_out[g])
        );
    end

    always_comb begin
        mem_we    = (is_load && !r_ready && load_store) || (r_state == ST_FWR);
        mem_waddr = (r_state == ST_FWR) ? r_addr : r_load_cnt[ADDR_W-1:0];
        mem_raddr = (r_state == ST_FRD) ? r_addr : r_read_cnt[ADDR_W-1:0];
        if (r_state == ST_FWR) begin
            mem_wdata = mem_rd;
            for (int l = 0; l < SIG_CH; l++) begin
                if (r_col) begin
                    mem_wdata.col_s[l] = lane_out[l];
                end else begin
                    mem_wdata.row_s[l] = lane_out[l][RS_W-1:0];
                end
            end
            if (r_col) begin
                mem_wdata.col_w = lane_out[SIG_CH][CW_W-1:0];
            end else begin
                mem_wdata.row_w = lane_out[SIG_CH][RW_W-1:0];
            end
        end else begin
            mem_wdata          = '0;
            mem_wdata.sig[0]   = i_sig_c0;
            mem_wdata.sig[1]   = i_sig_c1;
            mem_wdata.sig[2]   = i_sig_c2;
            mem_wdata.guide[0] = i_guide_c0;
            mem_wdata.guide[1] = i_guide_c1;
            mem_wdata.guide[2] = i_guide_c2;
        end
    end

    reas_ram #(
        .DW    ($bits(t_word)),
        .DEPTH (NPIX)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rd)
    );

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= 8'd10;
            r_decay <= ONE_DEC;
            r_fw    <= DIM_W'(MAX_WIDTH);
            r_fh    <= DIM_W'(MAX_HEIGHT);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_THRESH: r_thr   <= i_cfg_data[7:0];
                CFG_DECAY:  r_decay <= i_cfg_data[DEC_W-1:0];
                CFG_WIDTH:  r_fw    <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT: r_fh    <= i_cfg_data[DIM_W-1:0];
                default:    r_thr   <= r_thr;
            endcase
        end
    end

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_load_cnt <= '0;
            r_read_cnt <= '0;
            r_ready    <= 1'b0;
            r_w        <= DIM_W'(1);
            r_h        <= DIM_W'(1);
            r_size     <= CNT_W'(1);
            r_col      <= 1'b0;
            r_bwd      <= 1'b0;
            r_line     <= '0;
            r_idx      <= '0;
            r_addr     <= '0;
            r_div_cnt  <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (is_load && !r_ready) begin
                        r_load_cnt <= load_next;
                        if (load_next >= cur_size) begin
                            r_w        <= cw;
                            r_h        <= ch;
                            r_size     <= cur_size;
                            r_ready    <= 1'b1;
                            r_read_cnt <= '0;
                            r_col      <= 1'b0;
                            r_bwd      <= 1'b0;
                            r_line     <= '0;
                            r_idx      <= '0;
                            r_addr     <= '0;
                            r_state    <= ST_FRD;
                        end
                    end else if (is_read) begin
                        if (r_ready) begin
                            if (read_next >= r_size) begin
                                r_ready    <= 1'b0;
                                r_load_cnt <= '0;
                                r_read_cnt <= '0;
                            end else begin
                                r_read_cnt <= read_next;
                            end
                            r_state <= ST_RWAIT;
                        end else begin
                            r_state <= ST_PUSH;
                        end
                    end
                end
                ST_FRD: begin
                    r_state <= ST_FWR;
                end
                ST_FWR: begin
                    r_state <= ST_FRD;
                    if (!r_bwd) begin
                        if (r_idx == last_idx) begin
                            r_bwd <= 1'b1;
                        end else begin
                            r_idx  <= r_idx + DIM_W'(1);
                            r_addr <= r_addr + el_step;
                        end
                    end else if (r_idx != '0) begin
                        r_idx  <= r_idx - DIM_W'(1);
                        r_addr <= r_addr - el_step;
                    end else begin
                        r_bwd <= 1'b0;
                        if (r_line == n_lines - DIM_W'(1)) begin
                            if (r_col) begin
                                r_state <= ST_IDLE;
                            end else begin
                                r_col  <= 1'b1;
                                r_line <= '0;
                                r_addr <= '0;
                            end
                        end else begin
                            r_line <= r_line + DIM_W'(1);
                            r_addr <= r_addr + line_step;
                        end
                    end
                end
                ST_RWAIT: begin
                    r_div_cnt <= '0;
                    r_state   <= ST_DIV;
                end
                ST_DIV: begin
                    r_div_cnt <= r_div_cnt + 4'd1;
                    if (r_div_cnt == 4'd15) begin
                        r_state <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    if (push_fire) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // payload: guide history, divider, result staging
    always_ff @(posedge i_clk) begin
        if (r_state == ST_FWR) begin
            r_prev_guide <= mem_rd.guide;
        end
        if (is_read) begin
            r_res_status <= !r_ready;
            r_res_end    <= r_ready && (read_next >= r_size);
        end
        if (r_state == ST_RWAIT) begin
            r_dvs   <= {mem_rd.col_w, 15'd0};
            r_dzero <= (mem_rd.col_w == '0);
            for (int l = 0; l < SIG_CH; l++) begin
                r_rem[l]  <= mem_rd.col_s[l];
                r_q[l]    <= '0;
                r_dsat[l] <= ({8'd0, mem_rd.col_s[l]} >= {mem_rd.col_w, 16'd0});
            end
        end
        if (r_state == ST_DIV) begin
            r_dvs <= r_dvs >> 1;
            for (int l = 0; l < SIG_CH; l++) begin
                if ({7'd0, r_rem[l]} >= r_dvs) begin
                    r_rem[l] <= r_rem[l] - r_dvs[ACC_W-1:0];
                    r_q[l]   <= {r_q[l][14:0], 1'b1};
                end else begin
                    r_q[l]   <= {r_q[l][14:0], 1'b0};
                end
            end
        end
        if (push_fire) begin
            r_out_status <= r_res_status;
            r_out_end    <= r_res_end;
            for (int l = 0; l < SIG_CH; l++) begin
                if (r_res_status || r_dzero) begin
                    r_out_c[l] <= '0;
                end else if (r_dsat[l]) begin
                    r_out_c[l] <= 16'hFFFF;
                end else begin
                    r_out_c[l] <= r_q[l];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_c0    = r_out_c[0];
    assign o_out_c1    = r_out_c[1];
    assign o_out_c2    = r_out_c[2];
    assign o_status    = r_out_status;
    assign o_frame_end = r_out_end;

    a_mem_we_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == ST_IDLE || r_state == ST_FWR))
        else $error("frame memory written outside load or filter update");

    a_update_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FWR) |-> $past(r_state == ST_FRD))
        else $error("filter update without preceding memory read");

    a_idx_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FWR) |-> (r_idx < n_len))
        else $error("element index beyond line length");

    a_ready_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_ready) |-> $past(is_read))
        else $error("frame ready dropped without a read");

    a_div_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> !r_res_status)
        else $error("divider running for a not-ready read");

endmodule
`default_nettype wire

// ===== test/recursive_edge_aware_smoothing_top_tb.sv =====
`default_nettype none
module recursive_edge_aware_smoothing_top_tb import reas_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   SETTLE    = 40;

    typedef struct {
        logic [15:0] ch [3];
        logic        status;
        logic        frame_end;
    } t_pixel_out;

    class smoothing_scoreboard;
        logic [7:0]  thresh = 8'd10;
        logic [16:0] decay  = 17'd65536;
        logic [8:0]  fw     = 9'd256;
        logic [8:0]  fh     = 9'd256;
        int          load_cnt, read_cnt, done_w = 1, done_h = 1;
        bit          ready;
        logic [15:0] sig_mem   [NPIX][3];
        logic [7:0]  guide_mem [NPIX][3];
        logic [63:0] row_sum   [NPIX][3];
        logic [63:0] row_wt    [NPIX];
        logic [63:0] col_sum   [NPIX][3];
        logic [63:0] col_wt    [NPIX];
        logic [63:0] line_in   [MAX_WIDTH];
        logic [63:0] line_out  [MAX_WIDTH];
        bit          link      [MAX_WIDTH];
        t_pixel_out  pending_pixels [$];
        int          mismatches, reads_checked, frames_done;

        function void set_cfg(logic [1:0] idx, logic [16:0] val);
            case (idx)
                CFG_THRESH: thresh = val[7:0];
                CFG_DECAY:  decay  = val;
                CFG_WIDTH:  fw     = val[8:0];
                default:    fh     = val[8:0];
            endcase
        endfunction

        function int clamp_dim(logic [8:0] v, int hi);
            if (v < 1) return 1;
            if (v > hi) return hi;
            return int'(v);
        endfunction

        function bit guides_close(int p, int q);
            int diff;
            diff = 0;
            for (int c = 0; c < 3; c++)
                diff += (guide_mem[p][c] > guide_mem[q][c]) ?
                        guide_mem[p][c] - guide_mem[q][c] : guide_mem[q][c] - guide_mem[p][c];
            return diff <= int'(thresh) * 3;
        endfunction

        function logic [63:0] decayed(logic [63:0] a, logic [63:0] d);
            return (a >> 16) * d + (((a & 64'hFFFF) * d) >> 16);
        endfunction

        function logic [63:0] sat(logic [63:0] a, logic [63:0] b, logic [63:0] maxv);
            logic [63:0] s;
            s = a + b;
            return (s > maxv) ? maxv : s;
        endfunction

        // forward + backward recursion, centre counted once
        function void smooth_line(int n, logic [63:0] maxv, logic [63:0] d);
            logic [63:0] acc, prev, sub;
            acc = 0;
            for (int i = 0; i < n; i++) begin
                prev = (i > 0 && link[i]) ? decayed(acc, d) : 0;
                acc = sat(line_in[i], prev, maxv);
                line_out[i] = acc;
            end
            acc = 0;
            for (int i = n - 1; i >= 0; i--) begin
                prev = (i + 1 < n && link[i+1]) ? decayed(acc, d) : 0;
                acc = sat(line_in[i], prev, maxv);
                sub = (line_out[i] > line_in[i]) ? line_out[i] - line_in[i] : 0;
                line_out[i] = sat(sub, acc, maxv);
            end
        endfunction

        function void smooth_frame(int w, int h);
            logic [63:0] d;
            d = (decay > 17'd65536) ? 64'd65536 : 64'(decay);
            for (int y = 0; y < h; y++) begin
                for (int x = 0; x < w; x++)
                    link[x] = (x > 0) ? guides_close(x*h + y, (x-1)*h + y) : 0;
                for (int l = 0; l < 3; l++) begin
                    for (int x = 0; x < w; x++) line_in[x] = 64'(sig_mem[x*h + y][l]) << 16;
                    smooth_line(w, 64'(RS_MAX), d);
                    for (int x = 0; x < w; x++) row_sum[x*h + y][l] = line_out[x];
                end
                for (int x = 0; x < w; x++) line_in[x] = 64'd1 << 16;
                smooth_line(w, 64'(RW_MAX), d);
                for (int x = 0; x < w; x++) row_wt[x*h + y] = line_out[x];
            end
            for (int x = 0; x < w; x++) begin
                for (int y = 0; y < h; y++)
                    link[y] = (y > 0) ? guides_close(x*h + y, x*h + y - 1) : 0;
                for (int l = 0; l < 3; l++) begin
                    for (int y = 0; y < h; y++) line_in[y] = row_sum[x*h + y][l];
                    smooth_line(h, 64'(CS_MAX), d);
                    for (int y = 0; y < h; y++) col_sum[x*h + y][l] = line_out[y];
                end
                for (int y = 0; y < h; y++) line_in[y] = row_wt[x*h + y];
                smooth_line(h, 64'(CW_MAX), d);
                for (int y = 0; y < h; y++) col_wt[x*h + y] = line_out[y];
            end
        endfunction

        function void note_transfer(logic func, logic [15:0] s0, s1, s2,
                                    logic [7:0] g0, g1, g2);
            int w, h, size, p;
            t_pixel_out r;
            logic [63:0] q;
            if (func == FUNC_LOAD) begin
                if (ready) return;
                w = clamp_dim(fw, MAX_WIDTH);
                h = clamp_dim(fh, MAX_HEIGHT);
                size = w * h;
                if (load_cnt < size) begin
                    sig_mem[load_cnt] = '{s0, s1, s2};
                    guide_mem[load_cnt] = '{g0, g1, g2};
                    load_cnt++;
                end
                if (load_cnt >= size) begin
                    smooth_frame(w, h);
                    done_w = w;
                    done_h = h;
                    ready = 1;
                    read_cnt = 0;
                end
                return;
            end
            r.frame_end = 0;
            if (!ready) begin
                r.ch = '{0, 0, 0};
                r.status = 1;
            end else begin
                size = done_w * done_h;
                p = (read_cnt < size) ? read_cnt : size - 1;
                for (int l = 0; l < 3; l++) begin
                    q = (col_wt[p] != 0) ? col_sum[p][l] / col_wt[p] : 0;
                    r.ch[l] = (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
                end
                r.status = 0;
                read_cnt++;
                if (read_cnt >= size) begin
                    r.frame_end = 1;
                    ready = 0;
                    load_cnt = 0;
                    read_cnt = 0;
                    frames_done++;
                end
            end
            pending_pixels.insert(pending_pixels.size(), r);
        endfunction

        function void check_pixel(logic [15:0] c0, c1, c2, logic status, logic frame_end);
            t_pixel_out e;
            bit bad;
            if (pending_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: c0=%h c1=%h c2=%h status=%b end=%b",
                             c0, c1, c2, status, frame_end);
                return;
            end
            e = pending_pixels.pop_front();
            reads_checked++;
            bad = (c0 !== e.ch[0]) || (c1 !== e.ch[1]) || (c2 !== e.ch[2]) ||
                  (status !== e.status) || (frame_end !== e.frame_end);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp c0=%h c1=%h c2=%h st=%b end=%b, got %h %h %h %b %b",
                             e.ch[0], e.ch[1], e.ch[2], e.status, e.frame_end,
                             c0, c1, c2, status, frame_end);
            end
        endfunction
    endclass

    logic        i_clk, i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [16:0] i_cfg_data;
    logic        i_in_valid, o_in_ready, i_func;
    logic [15:0] i_sig_c0, i_sig_c1, i_sig_c2;
    logic [7:0]  i_guide_c0, i_guide_c1, i_guide_c2;
    logic        o_out_valid, i_out_ready;
    logic [15:0] o_out_c0, o_out_c1, o_out_c2;
    logic        o_status, o_frame_end;

    recursive_edge_aware_smoothing_top DUT (.*);

    smoothing_scoreboard sb;
    bit no_idle;
    int items_sent;

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #40ms;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        i_out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 21);
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_pixel(o_out_c0, o_out_c1, o_out_c2, o_status, o_frame_end);
    end

    task automatic send(logic func, logic [15:0] s0, s1, s2, logic [7:0] g0, g1, g2);
        if (!no_idle && $urandom_range(99) < 21) begin
            i_in_valid <= 0;
            do @(posedge i_clk); while ($urandom_range(99) < 21);
        end
        i_in_valid <= 1;
        i_func <= func;
        {i_sig_c0, i_sig_c1, i_sig_c2} <= {s0, s1, s2};
        {i_guide_c0, i_guide_c1, i_guide_c2} <= {g0, g1, g2};
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_transfer(func, s0, s1, s2, g0, g1, g2);
        items_sent++;
    endtask

    task automatic send_random(logic func);
        send(func, 16'($urandom), 16'($urandom), 16'($urandom),
             8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic read_px();
        send_random(FUNC_READ);
    endtask

    // wait until every expected result is back, then let the block settle
    task automatic drain();
        i_in_valid <= 0;
        while (sb.pending_pixels.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [16:0] thr, dec, w, h);
        logic [16:0] vals [4];
        vals = '{thr, dec, w, h};
        for (int i = 0; i < 4; i++) begin
            i_cfg_we <= 1;
            i_cfg_idx <= 2'(i);
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            sb.set_cfg(2'(i), vals[i]);
        end
        i_cfg_we <= 0;
    endtask

    // smooth: guides near a common base so many links form; else fully random
    task automatic load_frame(int n, bit smooth, bit extreme);
        logic [7:0] base [3];
        logic [15:0] s [3];
        logic [7:0] g [3];
        base = '{8'($urandom), 8'($urandom), 8'($urandom)};
        for (int i = 0; i < n; i++) begin
            for (int c = 0; c < 3; c++) begin
                s[c] = extreme ? ($urandom_range(1) ? 16'hFFFF : 16'h0000) : 16'($urandom);
                g[c] = smooth ? base[c] + 8'($urandom_range(0, 12)) : 8'($urandom);
            end
            if ($urandom_range(99) < 5) base[$urandom_range(2)] = 8'($urandom);
            send(FUNC_LOAD, s[0], s[1], s[2], g[0], g[1], g[2]);
        end
    endtask

    task automatic run_frame(int w, int h, bit smooth, bit extreme, bit noise);
        if (noise) repeat ($urandom_range(1, 2)) read_px();
        load_frame(w * h, smooth, extreme);
        if (noise) send_random(FUNC_LOAD);
        repeat (w * h) read_px();
        if (noise) read_px();
    endtask

    initial begin
        int w, h;
        sb = new();
        i_rst_n = 0;
        i_cfg_we = 0; i_cfg_idx = CFG_THRESH; i_cfg_data = 0;
        i_in_valid = 0; i_func = FUNC_LOAD;
        {i_sig_c0, i_sig_c1, i_sig_c2} = '0;
        {i_guide_c0, i_guide_c1, i_guide_c2} = '0;
        i_out_ready = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // zero sizes clamp to a single pixel; read before ready, load while ready
        write_regs(0, 0, 0, 0);
        read_px();
        send(FUNC_LOAD, 16'hFFFF, 16'h0000, 16'hFFFF, 8'hFF, 8'h00, 8'hFF);
        send(FUNC_LOAD, 16'h1234, 16'h5678, 16'h9ABC, 8'h00, 8'hFF, 8'h00);
        read_px();
        read_px();
        drain();
        write_regs(0, 17'd65536, 2, 2);
        send(FUNC_LOAD, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00);
        send(FUNC_LOAD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00, 8'h00, 8'h00);
        send(FUNC_LOAD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
        send(FUNC_LOAD, 16'h0001, 16'h8000, 16'h7FFF, 8'hFF, 8'hFF, 8'hFE);
        repeat (4) read_px();
        drain();
        // frame shrinks under a partial load: next load only starts filtering
        write_regs(255, 17'd40000, 4, 4);
        load_frame(5, 1, 0);
        drain();
        write_regs(255, 17'd40000, 2, 2);
        send_random(FUNC_LOAD);
        repeat (4) read_px();
        drain();
        // widest row, all linked, decay over the top clamps to full, extreme signal values
        write_regs(255, 17'h1FFFF, 17'h1FF, 1);
        no_idle = 1;
        run_frame(256, 1, 1, 1, 0);
        drain();
        write_regs(200, 17'd65535, 1, 17'h1FF);
        run_frame(1, 256, 1, 0, 0);
        no_idle = 0;
        drain();

        while (items_sent < 1300) begin
            if ($urandom_range(9) == 0) begin
                w = $urandom_range(1, 32);
                h = $urandom_range(1, 3);
            end else begin
                w = $urandom_range(1, 6);
                h = $urandom_range(1, 6);
            end
            write_regs($urandom_range(3) == 0 ? 17'($urandom_range(255)) : 17'($urandom_range(20)),
                       $urandom_range(3) == 0 ? 17'($urandom) : 17'($urandom_range(30000, 65536)),
                       17'(w), 17'(h));
            no_idle = ($urandom_range(7) == 0);
            run_frame(w, h, $urandom_range(3) != 0, $urandom_range(9) == 0,
                      $urandom_range(4) == 0);
            drain();
        end

        drain();
        $display("covered %0d transfers, %0d frames filtered, %0d results checked",
                 items_sent, sb.frames_done, sb.reads_checked);
        if (sb.mismatches == 0 && sb.pending_pixels.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches,
                     sb.pending_pixels.size());
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
